// ===== sv/pwstat_pkg.sv =====
package pwstat_pkg;

	localparam int LAT_W         = 20;
	localparam int CNT_W         = 11;
	localparam int SUM_W         = 30;
	localparam int CFG_W         = 11;
	localparam int MAX_CELLS_DEF = 1024;
	localparam int CAP_RESET     = 64;
	localparam int RES_DEPTH     = 2;

	typedef enum logic [1:0] {
		CMD_PING    = 2'd0,
		CMD_CLEAR   = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	// Ring word: reachable on top, then the latency flag, then the latency itself.
	typedef struct packed {
		logic             reach;
		logic             has_lat;
		logic [LAT_W-1:0] lat;
	} sample_t;

	localparam int SAMPLE_W = $bits(sample_t);

	typedef struct packed {
		logic    clear;
		logic    commit;
		sample_t sample;
		logic    last;
	} win_req_t;

	typedef struct packed {
		sample_t          sample;
		logic [CNT_W-1:0] fill;
		logic [CNT_W-1:0] reach_total;
		logic [SUM_W-1:0] lat_total;
		logic [CNT_W-1:0] lat_samples;
		logic             last;
	} result_t;

endpackage

// ===== sv/ping_window_statistics_core.sv =====
// Channel   Handshake             Word
// --------  --------------------  -----------------------------------------------
// input     in_valid / in_ready   command, reachable, latency_valid, latency_in
// output    out_valid / out_ready sample and window totals, last_of_run
// config    cfg_write             cfg_data = window_cells (no stall, no read-back)
//
// One word a cycle is taken in unless the input stalls; an outcome that commits
// a held failure as well holds the decode register for both its results, as the
// ring has a single write port. Results pass the decode register and the result
// queue. Reset is asynchronous; the ring has no clearing pass, only in-window
// entries are read. A two-deep result queue decouples output stalls from
// acceptance; while it is full, a word that needs a result stalls the input.
module ping_window_statistics_core #(
	parameter int MAX_CELLS = pwstat_pkg::MAX_CELLS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_write,
	input  logic [pwstat_pkg::CFG_W-1:0]     cfg_data,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       command,
	input  logic                             reachable,
	input  logic                             latency_valid,
	input  logic [pwstat_pkg::LAT_W-1:0]     latency_in,

	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             sample_reachable,
	output logic                             sample_has_latency,
	output logic [pwstat_pkg::LAT_W-1:0]     sample_latency,
	output logic [pwstat_pkg::CNT_W-1:0]     window_fill,
	output logic [pwstat_pkg::CNT_W-1:0]     reachable_total,
	output logic [pwstat_pkg::SUM_W-1:0]     latency_total,
	output logic [pwstat_pkg::CNT_W-1:0]     latency_samples,
	output logic                             last_of_run
);

	import pwstat_pkg::*;

	// Decode stage: the accepted word waits here until all its results are out.
	logic             valid_s1;
	cmd_t             command_s1;
	logic             reachable_s1;
	logic             latency_valid_s1;
	logic [LAT_W-1:0] latency_in_s1;

	// Hold-back state: settled once the first outcome after a restart is known.
	logic     settled_q, holding_q;
	logic     settled_d, holding_d;
	logic     done;
	logic     accept;
	logic     fifo_space;
	logic     res_valid;
	win_req_t req;
	result_t  res, out_word;
	sample_t  cur_sample;

	assign accept   = in_valid && in_ready;
	assign in_ready = !valid_s1 || done;

	// Current outcome as a sample: latency only counts when the ping was answered.
	always_comb begin
		cur_sample.reach   = reachable_s1;
		cur_sample.has_lat = reachable_s1 && latency_valid_s1;
		cur_sample.lat     = cur_sample.has_lat ? latency_in_s1 : '0;
	end

	always_comb begin
		req       = '0;
		settled_d = settled_q;
		holding_d = holding_q;
		done      = 1'b0;
		if (valid_s1) begin
			unique case (command_s1)
				CMD_CLEAR: begin
					req.clear = 1'b1;
					settled_d = 1'b0;
					holding_d = 1'b0;
					done      = 1'b1;
				end
				CMD_RESTART: begin
					settled_d = 1'b0;
					holding_d = 1'b0;
					done      = 1'b1;
				end
				CMD_PING: begin
					if (!settled_q && !reachable_s1 && !holding_q) begin
						// First failure after a restart: hold it back, no result.
						holding_d = 1'b1;
						done      = 1'b1;
					end else if (fifo_space) begin
						req.commit = 1'b1;
						settled_d  = 1'b1;
						holding_d  = 1'b0;
						if (!settled_q && !reachable_s1) begin
							// Second failure: commit the held one now, keep the
							// word and commit it as a settled outcome once the queue has space.
							req.sample = '0;
							req.last   = 1'b0;
						end else begin
							// A success drops any held failure; a settled outcome commits alone.
							req.sample = cur_sample;
							req.last   = 1'b1;
							done       = 1'b1;
						end
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
		end
		if (cfg_write) begin
			settled_d = 1'b0;
			holding_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			settled_q <= 1'b0;
			holding_q <= 1'b0;
		end else begin
			settled_q <= settled_d;
			holding_q <= holding_d;
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1       <= cmd_t'(command);
			reachable_s1     <= reachable;
			latency_valid_s1 <= latency_valid;
			latency_in_s1    <= latency_in;
		end
	end

	pwstat_window #(
		.MAX_CELLS (MAX_CELLS)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.req       (req),
		.res_valid (res_valid),
		.res       (res)
	);

	pwstat_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.space     (fifo_space),
		.pop_valid (out_valid),
		.pop_ready (out_ready),
		.pop_data  (out_word)
	);

	assign sample_reachable   = out_word.sample.reach;
	assign sample_has_latency = out_word.sample.has_lat;
	assign sample_latency     = out_word.sample.lat;
	assign window_fill        = out_word.fill;
	assign reachable_total    = out_word.reach_total;
	assign latency_total      = out_word.lat_total;
	assign latency_samples    = out_word.lat_samples;
	assign last_of_run        = out_word.last;

	// A commit never lands in a full result queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> fifo_space)
		else $error("result pushed into a full queue");

	// A failure is only ever held while the session is unsettled.
	a_hold_unsettled: assert property (@(posedge clk) disable iff (!arst_n)
		holding_q |-> !settled_q)
		else $error("failure held after the session settled");

	// Committing the held failure keeps its word for the second result.
	a_pair_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !req.last) |=> (valid_s1 && settled_q))
		else $error("word released before its second result");

	// A sample with latency always comes from a reachable ping.
	a_lat_reach: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.sample.has_lat) |-> res.sample.reach)
		else $error("latency committed for an unreachable sample");

endmodule

// ===== sv/pwstat_ram.sv =====
module pwstat_ram #(
	parameter int WIDTH = 22,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the contents from before a write in the same cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/pwstat_window.sv =====
module pwstat_window #(
	parameter int MAX_CELLS = pwstat_pkg::MAX_CELLS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [pwstat_pkg::CFG_W-1:0]     cfg_data,
	input  pwstat_pkg::win_req_t             req,
	output logic                             res_valid,
	output pwstat_pkg::result_t              res
);

	import pwstat_pkg::*;

	localparam int AW       = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int CW       = $clog2(MAX_CELLS + 1);
	localparam int PW       = CW + 1;
	localparam int CAP_INIT = (CAP_RESET < MAX_CELLS) ? CAP_RESET : MAX_CELLS;

	logic [AW-1:0]    oldest_q;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    cap_q;
	logic [SUM_W-1:0] acc_q;
	logic [CW-1:0]    latn_q;
	logic [CW-1:0]    reachn_q;
	sample_t          head_q;
	logic             fwd_q;
	sample_t          fwd_word_q;

	logic [AW-1:0]    oldest_inc, oldest_d, rd_addr, wr_addr;
	logic [CW-1:0]    fill_base, fill_d, cap_d, latn_d, reachn_d;
	logic [SUM_W-1:0] acc_d;
	logic [PW-1:0]    pos_sum;
	logic             evict, cfg_big;
	sample_t          wr_word, next_word, rd_word, head_d;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(MAX_CELLS - 1)) begin
			r = '0;
		end else begin
			r = p + AW'(1);
		end
		return r;
	endfunction

	pwstat_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_CELLS)
	) u_ring (
		.clk   (clk),
		.we    (req.commit),
		.waddr (wr_addr),
		.wdata (wr_word),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	assign wr_word    = req.sample;
	assign evict      = req.commit && (fill_q >= cap_q);
	assign oldest_inc = ptr_inc(oldest_q);
	assign fill_base  = evict ? (fill_q - CW'(1)) : fill_q;
	assign pos_sum    = PW'(evict ? oldest_inc : oldest_q) + PW'(fill_base);
	assign wr_addr    = (pos_sum >= PW'(MAX_CELLS)) ? AW'(pos_sum - PW'(MAX_CELLS))
	                                                 : AW'(pos_sum);
	assign next_word  = fwd_q ? fwd_word_q : rd_word;

	assign cfg_big = 32'(cfg_data) > 32'(MAX_CELLS);
	assign cap_d   = (cfg_data == '0) ? CW'(1) : (cfg_big ? CW'(MAX_CELLS) : CW'(cfg_data));

	always_comb begin
		oldest_d = oldest_q;
		fill_d   = fill_q;
		acc_d    = acc_q;
		latn_d   = latn_q;
		reachn_d = reachn_q;
		head_d   = head_q;
		if (req.commit) begin
			oldest_d = evict ? oldest_inc : oldest_q;
			fill_d   = fill_base + CW'(1);
			acc_d    = acc_q
			         - ((evict && head_q.has_lat) ? SUM_W'(head_q.lat) : '0)
			         + (wr_word.has_lat ? SUM_W'(wr_word.lat) : '0);
			latn_d   = latn_q - CW'(evict && head_q.has_lat) + CW'(wr_word.has_lat);
			reachn_d = reachn_q - CW'(evict && head_q.reach) + CW'(wr_word.reach);
			// Head: the word behind the evicted one, or the new word when alone.
			if (evict) begin
				head_d = (cap_q == CW'(1)) ? wr_word : next_word;
			end else if (fill_q == '0) begin
				head_d = wr_word;
			end
		end
		if (req.clear || cfg_write) begin
			oldest_d = '0;
			fill_d   = '0;
			acc_d    = '0;
			latn_d   = '0;
			reachn_d = '0;
		end
	end

	// Read ahead the word just behind the oldest one.
	assign rd_addr = ptr_inc(oldest_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			fill_q   <= '0;
			cap_q    <= CW'(CAP_INIT);
			acc_q    <= '0;
			latn_q   <= '0;
			reachn_q <= '0;
			fwd_q    <= 1'b0;
		end else begin
			oldest_q <= oldest_d;
			fill_q   <= fill_d;
			acc_q    <= acc_d;
			latn_q   <= latn_d;
			reachn_q <= reachn_d;
			fwd_q    <= req.commit && (wr_addr == rd_addr);
			if (cfg_write) begin
				cap_q <= cap_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		head_q     <= head_d;
		fwd_word_q <= wr_word;
	end

	assign res_valid       = req.commit;
	assign res.sample      = wr_word;
	assign res.fill        = CNT_W'(fill_d);
	assign res.reach_total = CNT_W'(reachn_d);
	assign res.lat_total   = acc_d;
	assign res.lat_samples = CNT_W'(latn_d);
	assign res.last        = req.last;

endmodule

// ===== sv/pwstat_res_fifo.sv =====
module pwstat_res_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pwstat_pkg::result_t push_data,
	output logic                space,
	output logic                pop_valid,
	input  logic                pop_ready,
	output pwstat_pkg::result_t pop_data
);

	import pwstat_pkg::*;

	localparam int PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;

	result_t          slot_q [RES_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(RES_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	assign space     = count_q < (PTR_W + 1)'(RES_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
